// File: rtl/core/cbc_pkg.sv
// Shared types, widths and codes of the command batch coalescer.
// Used by the front, back, top level and checker; depends on nothing.
`default_nettype none

package cbc_pkg;

    // Batch store depth, its derived index width and the count width.
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = 6;

    // Field widths of the payloads and state.
    localparam int OP_W    = 3;
    localparam int CMD_W   = 64;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 48;
    localparam int BYTES_W = 24;
    localparam int IVL_W   = 32;
    localparam int IF_W    = 8;
    localparam int TOTAL_W = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT   = 2'd3;

    // Register reset values.
    localparam logic [CNT_W-1:0]   RST_MAX_BATCH_SIZE  = 6'd32;
    localparam logic [BYTES_W-1:0] RST_MAX_BATCH_BYTES = 24'd1048576;
    localparam logic [IVL_W-1:0]   RST_FLUSH_INTERVAL  = 32'd1000;
    localparam logic [IF_W-1:0]    RST_MAX_IN_FLIGHT   = 8'd4;

    // Operation codes on the input channel.
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_SUBMIT = 3'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd2;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK    = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

    // Operation class after decode; unused op codes behave as a query.
    typedef enum logic [2:0] {
        CLS_APPEND,
        CLS_SUBMIT,
        CLS_FLUSH,
        CLS_DRAIN,
        CLS_ACK,
        CLS_QUERY
    } t_cls;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now_us;
        logic              leader;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [CMD_W-1:0]   entry_cmd;
        logic [LEN_W-1:0]   entry_len;
        logic               last;
        logic               accepted;
        logic [CNT_W-1:0]   flushed_count;
        logic [CNT_W-1:0]   pending_count;
        logic               should_flush;
        logic               can_send_more;
        logic [IF_W-1:0]    in_flight;
        logic [TOTAL_W-1:0] total_commands;
    } t_out_item;

    // Decoded item as it waits in the queue between front and back.
    typedef struct packed {
        t_cls              cls;
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now_us;
        logic              leader;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/command_batch_coalescer_top.sv
// Top level of the command batch coalescer: front decode and queue, back
// sequencer with the batch store. Depends on cbc_pkg, cbc_front, cbc_back.
//
// Input channel (i_in_valid, i_in_data, o_in_stall) carries one operation
// per transfer: append, submit, flush, drain, commit acknowledgment or query.
// Output channel (o_out_valid, o_out_data, i_out_stall) returns, per item,
// the entries sent by any flush it caused (kind 1, in stored order) and
// then one status result (kind 0, last 1).
// Configuration (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes
// the four limit registers; it is always ready and is meant for idle times.
// Per item the sequencer passes idle and status for an append, acknowledgment,
// query or refused flush, adding the due check for a submit stored at once and
// a flush walk, retry and due check for one stored after a flush. Every flush
// walk reads each stored entry out of the batch store. A status result passes the
// queue, sequencer and result stage. A two-item queue lets input run ahead.
// Reset (synchronous, active low) empties the batch, clears the credit
// count and command total, and loads the register defaults.
// An output stall holds the result register; the sequencer waits, the queue
// fills and o_in_stall rises, and nothing is lost.
`default_nettype none

module command_batch_coalescer_top import cbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_vld;
    t_cmd q_item;
    logic q_pop;

    // The configuration port is always ready for register writes.
    assign o_cfg_ready = 1'b1;

    // Decode and queue.
    cbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q_vld    (q_vld),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // Execution and results.
    cbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_vld     (q_vld),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// File: rtl/core/cbc_front.sv
// Front part of the coalescer: accepts input items, decodes the operation
// and holds them in a short queue for the back part. Depends on cbc_pkg.
`default_nettype none

module cbc_front import cbc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_q_vld,
    output t_cmd     o_q_item,
    input  logic     i_q_pop
);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill;
    logic               push;
    t_cmd               decoded;

    // Map the raw op code onto an operation class.
    function automatic t_cls decode_op(input logic [OP_W-1:0] op);
        t_cls cls;
        unique case (op)
            OP_APPEND: cls = CLS_APPEND;
            OP_SUBMIT: cls = CLS_SUBMIT;
            OP_FLUSH:  cls = CLS_FLUSH;
            OP_DRAIN:  cls = CLS_DRAIN;
            OP_ACK:    cls = CLS_ACK;
            default:   cls = CLS_QUERY;
        endcase
        return cls;
    endfunction

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] ptr);
        return (ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + Q_PTR_W'(1);
    endfunction

    // Input transfer whenever the queue has room.
    assign o_in_stall = (r_fill == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_vld    = (r_fill != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_comb begin
        decoded.cls    = decode_op(i_in_data.op);
        decoded.cmd    = i_in_data.cmd;
        decoded.len    = i_in_data.len;
        decoded.now_us = i_in_data.now_us;
        decoded.leader = i_in_data.leader;
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_q_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !i_q_pop) begin
                r_fill <= r_fill + Q_CNT_W'(1);
            end else if (!push && i_q_pop) begin
                r_fill <= r_fill - Q_CNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= decoded;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cbc_back.sv
// Back part of the coalescer: holds the batch store, counters and settings,
// runs each queued operation and walks flushes out through the output
// register. Depends on cbc_pkg.
`default_nettype none

module cbc_back import cbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_vld,
    input  t_cmd                  i_q_item,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FLUSH  = 3'd1;
    localparam logic [2:0] S_RETRY  = 3'd2;
    localparam logic [2:0] S_DUE    = 3'd3;
    localparam logic [2:0] S_STATUS = 3'd4;

    localparam logic RET_STATUS = 1'b0;
    localparam logic RET_RETRY  = 1'b1;

    // Settings.
    logic [CNT_W-1:0]   r_max_size;
    logic [BYTES_W-1:0] r_max_bytes;
    logic [IVL_W-1:0]   r_interval;
    logic [IF_W-1:0]    r_max_if;

    // Batch and credit state.
    logic [2:0]         r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [BYTES_W-1:0] r_bytes,   n_bytes;
    logic [TIME_W-1:0]  r_oldest,  n_oldest;
    logic [IF_W-1:0]    r_if,      n_if;
    logic [TOTAL_W-1:0] r_total,   n_total;

    // Current item and flush walk.
    t_cmd               r_item,    n_item;
    logic               r_acc,     n_acc;
    logic [CNT_W-1:0]   r_flushed, n_flushed;
    logic [CNT_W-1:0]   r_fl_cnt,  n_fl_cnt;
    logic [CNT_W-1:0]   r_fl_idx,  n_fl_idx;
    logic               r_fl_ret,  n_fl_ret;

    // Batch store.
    logic [CMD_W-1:0]   mem_cmd [MAX_ENTRIES];
    logic [LEN_W-1:0]   mem_len [MAX_ENTRIES];
    logic [CMD_W-1:0]   r_mem_cmd_q;
    logic [LEN_W-1:0]   r_mem_len_q;

    // Result stage ahead of the output register, and the output register.
    logic               r_a_vld;
    logic               r_a_entry;
    t_out_item          r_a_stat;
    logic               r_b_vld;
    t_out_item          r_b_data;

    t_cmd               cur;
    logic [CNT_W-1:0]   lim;
    logic [BYTES_W:0]   bytes_sum;
    logic               ap_ok;
    logic               credit;
    logic               fl_ok_norm;
    logic               fl_ok_force;
    logic [TIME_W-1:0]  age;
    logic               due;
    logic [CNT_W-1:0]   fl_base;
    logic [CNT_W-1:0]   fl_idx_nx;
    logic               do_append;
    logic               fl_start;
    logic               do_ack;
    logic               rd_en;
    logic               ld_status;
    logic               b_free;
    logic               a_move;
    logic               a_free;
    t_out_item          stat;
    t_out_item          entry_res;

    // The item being worked on: the queue head while idle, else the latched one.
    assign cur = (r_state == S_IDLE) ? i_q_item : r_item;

    // Append and flush conditions.
    assign lim         = (r_max_size < CNT_W'(MAX_ENTRIES)) ? r_max_size : CNT_W'(MAX_ENTRIES);
    assign bytes_sum   = {1'b0, r_bytes} + (BYTES_W + 1)'(cur.len);
    assign ap_ok       = (r_count < lim) && (bytes_sum <= {1'b0, r_max_bytes});
    assign credit      = (r_if < r_max_if);
    assign fl_ok_force = (r_count != '0) && cur.leader;
    assign fl_ok_norm  = fl_ok_force && credit;
    assign age         = cur.now_us - r_oldest;
    assign due         = (r_count != '0)
                         && ((r_count >= lim) || (r_bytes >= r_max_bytes)
                             || ((r_oldest != '0) && (age >= TIME_W'(r_interval))));
    assign fl_base     = (r_state == S_IDLE) ? '0 : r_flushed;
    assign fl_idx_nx   = r_fl_idx + CNT_W'(1);

    // Result pipeline handshake.
    assign b_free = !r_b_vld || !i_out_stall;
    assign a_move = r_a_vld && b_free;
    assign a_free = !r_a_vld || a_move;

    // Sequencer: decides what each cycle does to the batch state.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_oldest  = r_oldest;
        n_if      = r_if;
        n_total   = r_total;
        n_item    = r_item;
        n_acc     = r_acc;
        n_flushed = r_flushed;
        n_fl_cnt  = r_fl_cnt;
        n_fl_idx  = r_fl_idx;
        n_fl_ret  = r_fl_ret;
        do_append = 1'b0;
        fl_start  = 1'b0;
        do_ack    = 1'b0;
        rd_en     = 1'b0;
        ld_status = 1'b0;
        o_q_pop   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_acc     = 1'b0;
                    n_flushed = '0;
                    n_state   = S_STATUS;
                    unique case (i_q_item.cls)
                        CLS_APPEND: begin
                            do_append = ap_ok;
                            n_acc     = ap_ok;
                        end
                        CLS_SUBMIT: begin
                            if (ap_ok) begin
                                do_append = 1'b1;
                                n_acc     = 1'b1;
                                n_state   = S_DUE;
                            end else if (fl_ok_norm) begin
                                fl_start = 1'b1;
                                n_fl_ret = RET_RETRY;
                                n_state  = S_FLUSH;
                            end
                        end
                        CLS_FLUSH: begin
                            if (fl_ok_norm) begin
                                fl_start = 1'b1;
                                n_acc    = 1'b1;
                                n_fl_ret = RET_STATUS;
                                n_state  = S_FLUSH;
                            end
                        end
                        CLS_DRAIN: begin
                            if (fl_ok_force) begin
                                fl_start = 1'b1;
                                n_acc    = 1'b1;
                                n_fl_ret = RET_STATUS;
                                n_state  = S_FLUSH;
                            end
                        end
                        CLS_ACK: begin
                            do_ack = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (a_free) begin
                    rd_en    = 1'b1;
                    n_fl_idx = fl_idx_nx;
                    if (fl_idx_nx == r_fl_cnt) begin
                        n_state = (r_fl_ret == RET_RETRY) ? S_RETRY : S_STATUS;
                    end
                end
            end
            S_RETRY: begin
                if (ap_ok) begin
                    do_append = 1'b1;
                    n_acc     = 1'b1;
                    n_state   = S_DUE;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_DUE: begin
                if (due && fl_ok_norm) begin
                    fl_start = 1'b1;
                    n_fl_ret = RET_STATUS;
                    n_state  = S_FLUSH;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (a_free) begin
                    ld_status = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Store one entry; the first entry starts the age clock.
        if (do_append) begin
            if (r_count == '0) begin
                n_oldest = cur.now_us;
            end
            n_count = r_count + CNT_W'(1);
            n_bytes = bytes_sum[BYTES_W-1:0];
        end

        // A flush empties the batch at once and takes one credit; the walk
        // then reads the stored entries out.
        if (fl_start) begin
            n_fl_cnt  = r_count;
            n_fl_idx  = '0;
            n_count   = '0;
            n_bytes   = '0;
            n_oldest  = '0;
            n_total   = r_total + TOTAL_W'(r_count);
            n_if      = (r_if == '1) ? r_if : r_if + IF_W'(1);
            n_flushed = fl_base + r_count;
        end

        // A commit acknowledgment returns one credit.
        if (do_ack && (r_if != '0)) begin
            n_if = r_if - IF_W'(1);
        end
    end

    // Status result of the current item, from the state it leaves behind.
    always_comb begin
        stat.kind           = 1'b0;
        stat.entry_cmd      = '0;
        stat.entry_len      = '0;
        stat.last           = 1'b1;
        stat.accepted       = r_acc;
        stat.flushed_count  = r_flushed;
        stat.pending_count  = r_count;
        stat.should_flush   = due;
        stat.can_send_more  = credit;
        stat.in_flight      = r_if;
        stat.total_commands = r_total;
    end

    // Entry result from the registered store read.
    always_comb begin
        entry_res           = '0;
        entry_res.kind      = 1'b1;
        entry_res.entry_cmd = r_mem_cmd_q;
        entry_res.entry_len = r_mem_len_q;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_bytes  <= '0;
            r_oldest <= '0;
            r_if     <= '0;
            r_total  <= '0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_oldest <= n_oldest;
            r_if     <= n_if;
            r_total  <= n_total;
            if (rd_en || ld_status) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // Settings, written over the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size  <= RST_MAX_BATCH_SIZE;
            r_max_bytes <= RST_MAX_BATCH_BYTES;
            r_interval  <= RST_FLUSH_INTERVAL;
            r_max_if    <= RST_MAX_IN_FLIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_BATCH_SIZE:  r_max_size  <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_BATCH_BYTES: r_max_bytes <= i_cfg_data[BYTES_W-1:0];
                CFG_FLUSH_INTERVAL:  r_interval  <= i_cfg_data[IVL_W-1:0];
                CFG_MAX_IN_FLIGHT:   r_max_if    <= i_cfg_data[IF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-item payload registers.
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_acc     <= n_acc;
        r_flushed <= n_flushed;
        r_fl_cnt  <= n_fl_cnt;
        r_fl_idx  <= n_fl_idx;
        r_fl_ret  <= n_fl_ret;
        if (rd_en) begin
            r_a_entry <= 1'b1;
        end else if (ld_status) begin
            r_a_entry <= 1'b0;
            r_a_stat  <= stat;
        end
        if (a_move) begin
            r_b_data <= r_a_entry ? entry_res : r_a_stat;
        end
    end

    // Batch store: one write port for appends, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            mem_cmd[r_count[IDX_W-1:0]] <= cur.cmd;
            mem_len[r_count[IDX_W-1:0]] <= cur.len;
        end
        if (rd_en) begin
            r_mem_cmd_q <= mem_cmd[r_fl_idx[IDX_W-1:0]];
            r_mem_len_q <= mem_len[r_fl_idx[IDX_W-1:0]];
        end
    end

    assign o_out_valid = r_b_vld;
    assign o_out_data  = r_b_data;

endmodule

`default_nettype wire

// File: rtl/core/cbc_checker.sv
// Port-level checks of the command batch coalescer, bound to the top level.
// Depends on cbc_pkg and command_batch_coalescer_top.
`default_nettype none

module cbc_checker import cbc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input t_in_item              i_in_data,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input t_out_item             o_out_data,
    input logic                  i_out_stall,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // Reset leaves no result pending.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Reset empties the input queue, so the input is free right after.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // An entry result never closes an item and carries no status.
    a_entry_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind |->
            !o_out_data.last && !o_out_data.accepted
            && (o_out_data.flushed_count == '0) && (o_out_data.pending_count == '0))
        else $error("entry result carries status fields");

    // A status result always closes the item and carries no entry.
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.kind |->
            o_out_data.last && (o_out_data.entry_cmd == '0) && (o_out_data.entry_len == '0))
        else $error("status result malformed");

endmodule

bind command_batch_coalescer_top cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

// File: tb/tb_command_batch_coalescer_top.sv
// Self-checking testbench for command_batch_coalescer_top: drives commands, limit writes and
// output stalls, and checks every result transfer against a built-in batch predictor.
// Depends on cbc_pkg and the RTL of the coalescer.
`default_nettype none

module tb_command_batch_coalescer_top;
    import cbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes without a name in the package; the block treats them as a query.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Batch predictor and result scoreboard.
    class batch_checker;
        logic [CNT_W-1:0]   lim_size;
        logic [BYTES_W-1:0] lim_bytes;
        logic [IVL_W-1:0]   lim_ivl;
        logic [IF_W-1:0]    lim_in_flight;
        logic [CMD_W-1:0]   batch_cmd [MAX_ENTRIES];
        logic [LEN_W-1:0]   batch_len [MAX_ENTRIES];
        int unsigned        batch_count;
        logic [BYTES_W:0]   batch_bytes;
        logic [TIME_W-1:0]  oldest_us;
        logic [IF_W-1:0]    credits_used;
        logic [TOTAL_W-1:0] flushed_total;
        t_out_item          due_results [$];
        int unsigned        errors;

        function new();
            lim_size      = RST_MAX_BATCH_SIZE;
            lim_bytes     = RST_MAX_BATCH_BYTES;
            lim_ivl       = RST_FLUSH_INTERVAL;
            lim_in_flight = RST_MAX_IN_FLIGHT;
            batch_count   = 0;
            batch_bytes   = '0;
            oldest_us     = '0;
            credits_used  = '0;
            flushed_total = '0;
            errors        = 0;
        endfunction

        function void load_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_BATCH_SIZE:  lim_size = data[CNT_W-1:0];
                CFG_MAX_BATCH_BYTES: lim_bytes = data[BYTES_W-1:0];
                CFG_FLUSH_INTERVAL:  lim_ivl = data[IVL_W-1:0];
                CFG_MAX_IN_FLIGHT:   lim_in_flight = data[IF_W-1:0];
                default: ;
            endcase
        endfunction

        // The count limit can never exceed the store depth.
        function int unsigned count_cap();
            return (lim_size < MAX_ENTRIES) ? lim_size : MAX_ENTRIES;
        endfunction

        function bit try_store(t_in_item it);
            if (batch_count >= count_cap())
                return 0;
            if (batch_bytes + it.len > {1'b0, lim_bytes})
                return 0;
            if (batch_count == 0)
                oldest_us = it.now_us;
            batch_cmd[batch_count] = it.cmd;
            batch_len[batch_count] = it.len;
            batch_count++;
            batch_bytes += it.len;
            return 1;
        endfunction

        // An oldest time of zero switches the age test off for the batch.
        function bit flush_due(logic [TIME_W-1:0] now_us);
            logic [TIME_W-1:0] age;
            age = now_us - oldest_us;
            if (batch_count == 0)
                return 0;
            if (batch_count >= count_cap())
                return 1;
            if (batch_bytes >= {1'b0, lim_bytes})
                return 1;
            return (oldest_us != '0) && (age >= {16'd0, lim_ivl});
        endfunction

        // When a flush may go, queues one entry result per stored entry and empties the batch.
        function int unsigned send_batch(bit forced, bit leader);
            t_out_item   r;
            int unsigned sent;
            if (batch_count == 0 || !leader)
                return 0;
            if (!forced && !(credits_used < lim_in_flight))
                return 0;
            sent = batch_count;
            for (int i = 0; i < sent; i++) begin
                r = '0;
                r.kind = 1'b1;
                r.entry_cmd = batch_cmd[i];
                r.entry_len = batch_len[i];
                due_results.push_back(r);
            end
            flushed_total += TOTAL_W'(sent);
            if (credits_used != '1)
                credits_used++;
            batch_count = 0;
            batch_bytes = '0;
            oldest_us = '0;
            return sent;
        endfunction

        function void take_command(t_in_item it);
            t_out_item   r;
            int unsigned sent;
            bit          stored;
            sent = 0;
            stored = 0;
            case (it.op)
                OP_APPEND: stored = try_store(it);
                OP_SUBMIT: begin
                    stored = try_store(it);
                    if (!stored) begin
                        sent += send_batch(0, it.leader);
                        stored = try_store(it);
                    end
                    if (stored && flush_due(it.now_us))
                        sent += send_batch(0, it.leader);
                end
                OP_FLUSH, OP_DRAIN: begin
                    sent = send_batch(it.op == OP_DRAIN, it.leader);
                    stored = (sent > 0);
                end
                OP_ACK: begin
                    if (credits_used != '0)
                        credits_used--;
                end
                default: ;
            endcase
            r = '0;
            r.last = 1'b1;
            r.accepted = stored;
            r.flushed_count = CNT_W'(sent);
            r.pending_count = CNT_W'(batch_count);
            r.should_flush = flush_due(it.now_us);
            r.can_send_more = (credits_used < lim_in_flight);
            r.in_flight = credits_used;
            r.total_commands = flushed_total;
            due_results.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("field %s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $error("result transfer with nothing expected: kind=%0d last=%0d",
                       got.kind, got.last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("entry_cmd", want.entry_cmd, got.entry_cmd);
            check_field("entry_len", want.entry_len, got.entry_len);
            check_field("last", want.last, got.last);
            check_field("accepted", want.accepted, got.accepted);
            check_field("flushed_count", want.flushed_count, got.flushed_count);
            check_field("pending_count", want.pending_count, got.pending_count);
            check_field("should_flush", want.should_flush, got.should_flush);
            check_field("can_send_more", want.can_send_more, got.can_send_more);
            check_field("in_flight", want.in_flight, got.in_flight);
            check_field("total_commands", want.total_commands, got.total_commands);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    batch_checker          board;
    bit                    idle_on = 1'b0;
    bit                    hold_request = 1'b0;
    logic [TIME_W-1:0]     clock_us = 48'd1;
    int unsigned           cur_bytes = 1048576;

    command_batch_coalescer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Both channel monitors see the values from just before the edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            board.take_command(in_data);
        if (rst_n && out_valid && !out_stall)
            board.match_result(out_data);
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_left = 300;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = idle_on && ($urandom_range(99) < 12);
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offers one command and returns at the falling edge after its transfer.
    task automatic send_op(logic [OP_W-1:0] op, logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                           logic [TIME_W-1:0] now_us, logic leader);
        if (idle_on && $urandom_range(99) < 12) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.op = op;
        in_data.cmd = cmd;
        in_data.len = len;
        in_data.now_us = now_us;
        in_data.leader = leader;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (board.due_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        board.load_limit(idx, data);
        @(negedge clk);
    endtask

    task automatic set_limits(int unsigned size, int unsigned bytes, int unsigned ivl,
                              int unsigned flights);
        wait_drained();
        cfg_write(CFG_MAX_BATCH_SIZE, size);
        cfg_write(CFG_MAX_BATCH_BYTES, bytes);
        cfg_write(CFG_FLUSH_INTERVAL, ivl);
        cfg_write(CFG_MAX_IN_FLIGHT, flights);
        cfg_valid = 1'b0;
        cur_bytes = bytes;
    endtask

    // Mostly steady time steps, with jumps to zero, to random times and near the wrap.
    function automatic logic [TIME_W-1:0] next_time();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4)
            clock_us = '0;
        else if (pick < 9)
            clock_us = {16'($urandom), 32'($urandom)};
        else if (pick < 11)
            clock_us = '1 - TIME_W'($urandom_range(0, 2000));
        else if (pick < 20)
            clock_us += TIME_W'($urandom_range(0, 100000));
        else
            clock_us += TIME_W'($urandom_range(0, 400));
        return clock_us;
    endfunction

    // Lengths sized to the byte limit so that batches fill over several appends.
    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned pick;
        int unsigned span;
        span = (cur_bytes / 6 > 65535) ? 65535 : cur_bytes / 6;
        pick = $urandom_range(99);
        if (pick < 25)
            return LEN_W'($urandom_range(0, 15));
        else if (pick < 75)
            return LEN_W'($urandom_range(0, span));
        else if (pick < 85)
            return '1;
        else
            return LEN_W'($urandom);
    endfunction

    task automatic random_phase(int unsigned count);
        logic [OP_W-1:0] op;
        int unsigned     pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 34)
                op = OP_APPEND;
            else if (pick < 64)
                op = OP_SUBMIT;
            else if (pick < 72)
                op = OP_FLUSH;
            else if (pick < 79)
                op = OP_DRAIN;
            else if (pick < 92)
                op = OP_ACK;
            else if (pick < 97)
                op = OP_QUERY;
            else
                op = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
            send_op(op, {$urandom, $urandom}, pick_len(), next_time(),
                    $urandom_range(99) < 88);
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset limits: time zero, age edge, flush refusals.
        send_op(OP_QUERY, '0, '0, '0, 1'b1);
        send_op(OP_APPEND, '1, '1, '0, 1'b1);
        send_op(OP_APPEND, '0, '0, '1, 1'b1);
        send_op(OP_FLUSH, '0, '0, 48'd10, 1'b0);
        send_op(OP_FLUSH, '0, '0, 48'd10, 1'b1);
        send_op(OP_ACK, '0, '0, 48'd20, 1'b1);
        send_op(OP_ACK, '0, '0, 48'd20, 1'b1);
        send_op(OP_SPARE_LO, {$urandom, $urandom}, 16'd7, 48'd30, 1'b1);
        send_op(OP_SPARE_HI, {$urandom, $urandom}, 16'd9, 48'd30, 1'b0);
        send_op(OP_DRAIN, '0, '0, 48'd40, 1'b1);
        send_op(OP_APPEND, 64'd1, 16'd100, 48'd1000, 1'b1);
        send_op(OP_QUERY, '0, '0, 48'd1999, 1'b1);
        send_op(OP_QUERY, '0, '0, 48'd2000, 1'b1);
        send_op(OP_SUBMIT, 64'd2, 16'd5, 48'd2000, 1'b1);

        // Tight limits and no credit: double refusal of a submit, drain only.
        set_limits(2, 100, 1000, 0);
        send_op(OP_SUBMIT, 64'd3, 16'd60, 48'd10, 1'b1);
        send_op(OP_SUBMIT, 64'd4, 16'd60, 48'd11, 1'b1);
        send_op(OP_FLUSH, '0, '0, 48'd12, 1'b1);
        send_op(OP_DRAIN, '0, '0, 48'd13, 1'b0);
        send_op(OP_DRAIN, '0, '0, 48'd14, 1'b1);
        send_op(OP_APPEND, 64'd5, 16'd40, 48'd15, 1'b1);
        send_op(OP_APPEND, 64'd6, 16'd60, 48'd16, 1'b1);
        send_op(OP_APPEND, 64'd7, 16'd1, 48'd17, 1'b1);
        send_op(OP_DRAIN, '0, '0, 48'd18, 1'b1);

        // Random phases; the first one without any idling.
        set_limits(8, 200000, 500, 3);
        random_phase(40);

        // Count limit above the store depth, widest limits, long output hold-off.
        set_limits(63, 16777215, 32'hFFFF_FFFF, 2);
        idle_on = 1'b1;
        hold_request = 1'b1;
        random_phase(40);

        set_limits(3, 1, 0, 1);
        random_phase(20);

        set_limits(5, 150000, 2000, 0);
        random_phase(20);

        // Count limit zero refuses every append.
        set_limits(0, 5000, 100, 6);
        random_phase(10);

        // One-entry batches: every submit flushes and takes a credit.
        set_limits(1, 16777215, 32'hFFFF_FFFF, 255);
        repeat (20)
            send_op(OP_SUBMIT, {$urandom, $urandom}, pick_len(), next_time(), 1'b1);
        send_op(OP_DRAIN, '0, '0, next_time(), 1'b1);
        repeat (3)
            send_op(OP_ACK, '0, '0, next_time(), 1'b1);

        set_limits(32, 60000, 300, 255);
        random_phase(20);

        wait_drained();
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/cbc_pkg.sv
rtl/core/cbc_front.sv
rtl/core/cbc_back.sv
rtl/core/command_batch_coalescer_top.sv
rtl/core/cbc_checker.sv
tb/tb_command_batch_coalescer_top.sv
